// ===== src/mi4_pkg.sv =====
`default_nettype none
package mi4_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // internal fixed point: 64-bit signed, magnitudes clamped to 2^62-1
   localparam int ACC_W     = 64;
   localparam int MAG_W     = 62;
   localparam int MUL_SPLIT = 32;
   localparam int PHI_W     = WORD_WIDTH + MAG_W - MUL_SPLIT;
   localparam int SUM_W     = WORD_WIDTH + MAG_W;
   localparam int SHR_W     = SUM_W - FRAC_BITS;
   localparam int QW        = WORD_WIDTH + 1;
   localparam int NS_W      = MAG_W + FRAC_BITS;
   localparam int NHI_W     = NS_W - QW;
   localparam int REM_W     = MAG_W + 1;
   localparam int DCNT_W    = $clog2(QW);

   localparam logic signed [ACC_W-1:0] BOUND = ACC_W'({MAG_W{1'b1}});

   localparam logic [3:0] PN_T1_LO  = 4'd0;
   localparam logic [3:0] PN_T1_HI  = 4'd1;
   localparam logic [3:0] PN_T2_HI  = 4'd3;
   localparam logic [3:0] PN_T3_HI  = 4'd5;
   localparam logic [3:0] PN_OUTER  = 4'd6;
   localparam logic [3:0] PN_COF    = 4'd8;
   localparam logic [3:0] PN_DET    = 4'd9;
   localparam logic [3:0] PN_DET_LAST = 4'd12;
   localparam logic [3:0] LAST_IDX  = 4'd15;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_A, ST_RD_B, ST_OPB, ST_MUL0, ST_MUL1, ST_SUM,
      ST_ACC0, ST_ACC1, ST_DRD, ST_DLOAD, ST_DIV, ST_OUT
   } state_type;

   typedef enum logic [1:0] {SRC_MAT, SRC_T, SRC_COF} bsrc_type;
   typedef enum logic [1:0] {WB_NONE, WB_T, WB_COF, WB_DET} wb_type;

   typedef struct packed {
      logic       mat_we;
      logic [3:0] mat_rd_addr;
      logic [3:0] cof_rd_addr;
      logic       lat_a;
      logic       lat_b;
      bsrc_type   b_src;
      logic [1:0] t_sel;
      logic       mul_lo;
      logic       mul_hi;
      logic       sum_en;
      logic       prod_en;
      logic       sub;
      logic       acc_en;
      wb_type     wb;
      logic [3:0] cof_wr_addr;
      logic       cof_neg;
      logic       div_load;
      logic       div_step;
      logic       out_load;
      logic [3:0] out_index;
   } cmd_type;

   typedef struct packed {
      logic det_zero;
      logic out_free;
   } status_type;

   // minor operand positions {row, col} inside the 3x3 minor, per product number
   function automatic logic [3:0] op_a_pos(input logic [3:0] pn);
      logic [3:0] p;
      case (pn)
         4'd0: p = 4'b0101;
         4'd1: p = 4'b0110;
         4'd2: p = 4'b0100;
         4'd3: p = 4'b0110;
         4'd4: p = 4'b0100;
         4'd5: p = 4'b0101;
         4'd6: p = 4'b0000;
         4'd7: p = 4'b0001;
         4'd8: p = 4'b0010;
         default: p = 4'b0000;
      endcase
      return p;
   endfunction

   function automatic logic [3:0] op_b_pos(input logic [3:0] pn);
      logic [3:0] p;
      case (pn)
         4'd0: p = 4'b1010;
         4'd1: p = 4'b1001;
         4'd2: p = 4'b1010;
         4'd3: p = 4'b1000;
         4'd4: p = 4'b1001;
         4'd5: p = 4'b1000;
         default: p = 4'b0000;
      endcase
      return p;
   endfunction

   function automatic logic [1:0] skip(input logic [1:0] x, input logic [1:0] k);
      return (k < x) ? k : k + 2'd1;
   endfunction

   function automatic logic [3:0] minor_addr(input logic [1:0] r, input logic [1:0] c,
                                             input logic [3:0] pos);
      return {skip(r, pos[3:2]), skip(c, pos[1:0])};
   endfunction

endpackage
`default_nettype wire

// ===== src/mi4_ctrl.sv =====
`default_nettype none
module mi4_ctrl import mi4_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [3:0] req_element_index,
   output logic       req_stall,
   output cmd_type    cmd,
   input  status_type status
);

   state_type         state_ff, state_in;
   logic [3:0]        pn_ff, pn_in;
   logic [3:0]        idx_ff, idx_in;
   logic [DCNT_W-1:0] div_cnt_ff, div_cnt_in;

   logic [1:0] row, col, dc;
   logic       det_phase;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pn_ff      <= '0;
         idx_ff     <= '0;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pn_ff      <= pn_in;
         idx_ff     <= idx_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   assign row       = idx_ff[3:2];
   assign col       = idx_ff[1:0];
   assign det_phase = (pn_ff >= PN_DET);
   assign dc        = 2'(pn_ff - PN_DET);

   always_comb begin
      state_in   = state_ff;
      pn_in      = pn_ff;
      idx_in     = idx_ff;
      div_cnt_in = div_cnt_ff;
      req_stall  = 1'b1;
      cmd        = '0;
      cmd.b_src  = SRC_MAT;
      cmd.wb     = WB_NONE;
      cmd.cof_wr_addr = {col, row};
      cmd.cof_neg     = row[0] ^ col[0];
      cmd.out_index   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.mat_we = 1'b1;
               if (req_element_index == LAST_IDX) begin
                  state_in = ST_RD_A;
                  pn_in    = '0;
                  idx_in   = '0;
               end
            end
         end
         ST_RD_A: begin
            cmd.mat_rd_addr = det_phase ? {2'b00, dc} : minor_addr(row, col, op_a_pos(pn_ff));
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            cmd.lat_a       = 1'b1;
            cmd.mat_rd_addr = minor_addr(row, col, op_b_pos(pn_ff));
            cmd.cof_rd_addr = {dc, 2'b00};
            state_in = ST_OPB;
         end
         ST_OPB: begin
            cmd.lat_b = 1'b1;
            cmd.t_sel = 2'(pn_ff - PN_OUTER);
            if (det_phase)
               cmd.b_src = SRC_COF;
            else if (pn_ff >= PN_OUTER)
               cmd.b_src = SRC_T;
            state_in = ST_MUL0;
         end
         ST_MUL0: begin
            cmd.mul_lo = 1'b1;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul_hi = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in = ST_ACC0;
         end
         ST_ACC0: begin
            cmd.prod_en = 1'b1;
            cmd.sub     = pn_ff[0] && !det_phase;
            state_in = ST_ACC1;
         end
         ST_ACC1: begin
            cmd.acc_en = 1'b1;
            cmd.t_sel  = pn_ff[2:1];
            state_in = ST_RD_A;
            pn_in    = pn_ff + 4'd1;
            if (pn_ff == PN_T1_HI || pn_ff == PN_T2_HI || pn_ff == PN_T3_HI) begin
               cmd.wb = WB_T;
            end else if (pn_ff == PN_COF) begin
               cmd.wb = WB_COF;
               if (idx_ff == LAST_IDX) begin
                  idx_in = '0;
               end else begin
                  idx_in = idx_ff + 4'd1;
                  pn_in  = PN_T1_LO;
               end
            end else if (pn_ff == PN_DET_LAST) begin
               cmd.wb   = WB_DET;
               state_in = ST_DRD;
            end
         end
         ST_DRD: begin
            cmd.cof_rd_addr = idx_ff;
            state_in = status.det_zero ? ST_OUT : ST_DLOAD;
         end
         ST_DLOAD: begin
            cmd.div_load = 1'b1;
            div_cnt_in   = DCNT_W'(QW - 1);
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == '0)
               state_in = ST_OUT;
            else
               div_cnt_in = div_cnt_ff - 1'b1;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 4'd1;
                  state_in = ST_DRD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_element_index == LAST_IDX) |=>
      (state_ff == ST_RD_A && pn_ff == PN_T1_LO && idx_ff == 4'd0))
      else $error("run did not start on last element");
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded over a waiting beat");
   a_div_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_cnt_ff != '0) |=>
      (state_ff == ST_DIV && div_cnt_ff == $past(div_cnt_ff) - 1'b1))
      else $error("divider count skipped");
`endif

endmodule
`default_nettype wire

// ===== src/mi4_datapath.sv =====
`default_nettype none
module mi4_datapath import mi4_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output status_type                   status,
   input  logic signed [WORD_WIDTH-1:0] req_element_value,
   input  logic [3:0]                   req_element_index,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [WORD_WIDTH-1:0] rsp_result_value,
   output logic [3:0]                   rsp_result_index,
   output logic                         rsp_singular,
   output logic                         rsp_saturated,
   output logic                         rsp_last_result
);

   logic signed [WORD_WIDTH-1:0] mat_mem [16];
   logic signed [WORD_WIDTH-1:0] mat_rdata_ff;
   logic signed [ACC_W-1:0]      cof_mem [16];
   logic signed [ACC_W-1:0]      cof_rdata_ff;

   logic                  a_neg_ff, mul_neg_ff;
   logic [WORD_WIDTH-1:0] a_mag_ff;
   logic [MAG_W-1:0]      b_mag_ff;
   logic [2*MUL_SPLIT-1:0] plo_ff;
   logic [PHI_W-1:0]      phi_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic signed [ACC_W-1:0] prod_ff, acc_ff;
   logic signed [ACC_W-1:0] t0_ff, t1_ff, t2_ff;
   logic                  det_neg_ff;
   logic [MAG_W-1:0]      det_mag_ff;

   logic [REM_W-1:0]      rem_ff;
   logic [QW-1:0]         nlow_ff, q_ff;
   logic                  ovf_ff, qneg_ff;

   logic                         rsp_valid_ff, rsp_singular_ff, rsp_saturated_ff;
   logic                         rsp_last_ff;
   logic signed [WORD_WIDTH-1:0] rsp_value_ff;
   logic [3:0]                   rsp_index_ff;

   logic signed [ACC_W-1:0] b_val, b_abs, cof_abs, acc_sum, acc_clamp, wr_val;
   logic [SHR_W-1:0]        shr;
   logic [MAG_W-1:0]        p_mag;
   logic [NS_W-1:0]         nsh;
   logic [REM_W-1:0]        r2, dext;
   logic                    pos_sat, neg_sat;
   logic signed [WORD_WIDTH-1:0] val_out;

   // element and cofactor stores
   always_ff @(posedge clock) begin
      if (cmd.mat_we)
         mat_mem[req_element_index] <= req_element_value;
      mat_rdata_ff <= mat_mem[cmd.mat_rd_addr];
      if (cmd.acc_en && cmd.wb == WB_COF)
         cof_mem[cmd.cof_wr_addr] <= wr_val;
      cof_rdata_ff <= cof_mem[cmd.cof_rd_addr];
   end

   always_comb begin
      case (cmd.b_src)
         SRC_MAT: b_val = ACC_W'(mat_rdata_ff);
         SRC_T: begin
            case (cmd.t_sel)
               2'd0:    b_val = t0_ff;
               2'd1:    b_val = t1_ff;
               default: b_val = t2_ff;
            endcase
         end
         SRC_COF: b_val = cof_rdata_ff;
         default: b_val = '0;
      endcase
      b_abs = b_val[ACC_W-1] ? -b_val : b_val;
      shr   = sum_ff[SUM_W-1:FRAC_BITS];
      p_mag = (|shr[SHR_W-1:MAG_W]) ? {MAG_W{1'b1}} : shr[MAG_W-1:0];
      acc_sum = acc_ff + prod_ff;
      if (acc_sum > BOUND)
         acc_clamp = BOUND;
      else if (acc_sum < -BOUND)
         acc_clamp = -BOUND;
      else
         acc_clamp = acc_sum;
      wr_val  = cmd.cof_neg ? -acc_clamp : acc_clamp;
      cof_abs = cof_rdata_ff[ACC_W-1] ? -cof_rdata_ff : cof_rdata_ff;
      nsh     = {cof_abs[MAG_W-1:0], {FRAC_BITS{1'b0}}};
      dext    = REM_W'(det_mag_ff);
      r2      = {rem_ff[MAG_W-1:0], nlow_ff[QW-1]};
   end

   // multiply and accumulate
   always_ff @(posedge clock) begin
      if (cmd.lat_a) begin
         a_neg_ff <= mat_rdata_ff[WORD_WIDTH-1];
         a_mag_ff <= mat_rdata_ff[WORD_WIDTH-1] ? WORD_WIDTH'(-mat_rdata_ff)
                                                 : WORD_WIDTH'(mat_rdata_ff);
      end
      if (cmd.lat_b) begin
         b_mag_ff   <= b_abs[MAG_W-1:0];
         mul_neg_ff <= a_neg_ff ^ b_val[ACC_W-1];
      end
      if (cmd.mul_lo)
         plo_ff <= a_mag_ff * b_mag_ff[MUL_SPLIT-1:0];
      if (cmd.mul_hi)
         phi_ff <= a_mag_ff * b_mag_ff[MAG_W-1:MUL_SPLIT];
      if (cmd.sum_en)
         sum_ff <= SUM_W'(plo_ff) + (SUM_W'(phi_ff) << MUL_SPLIT);
      if (cmd.prod_en)
         prod_ff <= (mul_neg_ff ^ cmd.sub) ? -ACC_W'(p_mag) : ACC_W'(p_mag);
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= (cmd.wb == WB_NONE) ? acc_clamp : '0;
      end
      if (cmd.acc_en && cmd.wb == WB_T) begin
         case (cmd.t_sel)
            2'd0:    t0_ff <= acc_clamp;
            2'd1:    t1_ff <= acc_clamp;
            default: t2_ff <= acc_clamp;
         endcase
      end
      if (cmd.acc_en && cmd.wb == WB_DET) begin
         det_neg_ff <= acc_clamp[ACC_W-1];
         det_mag_ff <= acc_clamp[ACC_W-1] ? MAG_W'(-acc_clamp) : acc_clamp[MAG_W-1:0];
      end
   end

   // restoring divider, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff  <= REM_W'(nsh[NS_W-1:QW]);
         nlow_ff <= nsh[QW-1:0];
         ovf_ff  <= REM_W'(nsh[NS_W-1:QW]) >= dext;
         qneg_ff <= cof_rdata_ff[ACC_W-1] ^ det_neg_ff;
         q_ff    <= '0;
      end else if (cmd.div_step) begin
         nlow_ff <= {nlow_ff[QW-2:0], 1'b0};
         if (r2 >= dext) begin
            rem_ff <= r2 - dext;
            q_ff   <= {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff <= r2;
            q_ff   <= {q_ff[QW-2:0], 1'b0};
         end
      end
   end

   assign pos_sat = ovf_ff | q_ff[QW-1] | q_ff[QW-2];
   assign neg_sat = ovf_ff | q_ff[QW-1] | (q_ff[QW-2] & (|q_ff[QW-3:0]));

   always_comb begin
      if (qneg_ff)
         val_out = neg_sat ? {1'b1, {(WORD_WIDTH-1){1'b0}}} : -q_ff[WORD_WIDTH-1:0];
      else
         val_out = pos_sat ? {1'b0, {(WORD_WIDTH-1){1'b1}}} : q_ff[WORD_WIDTH-1:0];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.out_load)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
      if (cmd.out_load) begin
         rsp_index_ff     <= cmd.out_index;
         rsp_last_ff      <= (cmd.out_index == LAST_IDX);
         rsp_singular_ff  <= status.det_zero;
         rsp_saturated_ff <= !status.det_zero && (qneg_ff ? neg_sat : pos_sat);
         rsp_value_ff     <= status.det_zero ? '0 : val_out;
      end
   end

   assign status.det_zero = (det_mag_ff == '0);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_singular     = rsp_singular_ff;
   assign rsp_saturated    = rsp_saturated_ff;
   assign rsp_last_result  = rsp_last_ff;

endmodule
`default_nettype wire

// ===== src/matrix4_inverse_adjugate.sv =====
`default_nettype none
// 4x4 matrix inverse by cofactors, signed Q16.16. Send the sixteen elements
// as req beats tagged with their row-major index; a beat with index 15 starts
// a run, and element writes may come in any order before it. The run forms
// the sixteen 3x3 cofactors on one multiply unit (each product takes a low and
// a high partial product, 148 products in all), takes the determinant along
// the first row, then divides each adjugate entry by it in a one-bit-per-cycle
// divider. req_stall stays high for the whole run. Sixteen rsp beats follow in
// row-major order, the last one marked by rsp_last_result. A zero determinant
// gives all-zero results with rsp_singular set; a result outside the Q16.16
// range is clipped with rsp_saturated set. Intermediate clamping at +-(2^62-1)
// is silent. The last result may sit in the output register while a new
// matrix loads.
module matrix4_inverse_adjugate import mi4_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   // element beats in
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [WORD_WIDTH-1:0] req_element_value,
   input  logic [3:0]                   req_element_index,
   // inverse beats out
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [WORD_WIDTH-1:0] rsp_result_value,
   output logic [3:0]                   rsp_result_index,
   output logic                         rsp_singular,
   output logic                         rsp_saturated,
   output logic                         rsp_last_result
);

   cmd_type    cmd;
   status_type status;

   // sequencer: product schedule, divider count, output handshake
   mi4_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_element_index (req_element_index),
      .req_stall         (req_stall),
      .cmd               (cmd),
      .status            (status)
   );

   // stores, multiplier, accumulator, divider and result register
   mi4_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_element_value (req_element_value),
      .req_element_index (req_element_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_value  (rsp_result_value),
      .rsp_result_index  (rsp_result_index),
      .rsp_singular      (rsp_singular),
      .rsp_saturated     (rsp_saturated),
      .rsp_last_result   (rsp_last_result)
   );

endmodule
`default_nettype wire

// ===== sim/matrix4_inverse_adjugate_tb.sv =====
`default_nettype none
module matrix4_inverse_adjugate_tb;
   import mi4_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // how a run's sixteen results are to be checked
   typedef enum logic [1:0] {CHK_MODEL, CHK_IDENTITY, CHK_SINGULAR} chk_mode_type;

   typedef struct packed {
      logic [31:0]  value;
      logic [3:0]   index;
      chk_mode_type mode;
   } stim_row_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] value;
      logic [3:0]            index;
      logic                  singular;
      logic                  saturated;
      logic                  last;
   } inv_elem_type;

   localparam longint FX_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam int STALL_LIMIT = 30000;   // cycles with no beat on either side
   localparam int TAIL_CYCLES = 2000;    // settle time after the last result
   localparam int ITEM_GOAL = 280;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic signed [WORD_WIDTH-1:0] req_element_value = '0;
   logic [3:0]                   req_element_index = '0;
   chk_mode_type                 req_mode = CHK_MODEL;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [WORD_WIDTH-1:0] rsp_result_value;
   logic [3:0]                   rsp_result_index;
   logic                         rsp_singular;
   logic                         rsp_saturated;
   logic                         rsp_last_result;

   matrix4_inverse_adjugate dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_element_value(req_element_value), .req_element_index(req_element_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_value(rsp_result_value), .rsp_result_index(rsp_result_index),
      .rsp_singular(rsp_singular), .rsp_saturated(rsp_saturated),
      .rsp_last_result(rsp_last_result)
   );

   always #5 clock = ~clock;

   // predictor state: our own copy of the element store
   logic [31:0]   elem_copy [16];
   inv_elem_type  inverse_q [$];
   int            mismatches = 0;
   int            rsp_beats = 0;
   int            items_sent = 0;
   int            idle_cycles = 0;

   // ---------------------------------------------------------------- predictor
   // sums and products are clamped to +-(2^62-1)
   function automatic longint clamp_sum(input longint a, input longint b);
      logic signed [65:0] s;
      s = a + b;
      if (s > FX_LIM) return FX_LIM;
      if (s < -FX_LIM) return -FX_LIM;
      return longint'(s);
   endfunction

   // exact product, magnitude truncated after the fraction shift
   function automatic longint fx_product(input longint a, input longint b);
      logic [127:0] p;
      logic [63:0]  x, y, mag;
      logic         neg;
      neg = (a < 0) != (b < 0);
      x = (a < 0) ? -a : a;
      y = (b < 0) ? -b : b;
      p = {64'b0, x} * {64'b0, y};
      p = p >> FRAC_BITS;
      mag = (p > 128'(FX_LIM)) ? 64'(FX_LIM) : p[63:0];
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint minor_det(input longint m [9]);
      longint t1, t2, t3;
      t1 = clamp_sum(fx_product(m[4], m[8]), -fx_product(m[5], m[7]));
      t2 = clamp_sum(fx_product(m[3], m[8]), -fx_product(m[5], m[6]));
      t3 = clamp_sum(fx_product(m[3], m[7]), -fx_product(m[4], m[6]));
      return clamp_sum(clamp_sum(fx_product(m[0], t1), -fx_product(m[1], t2)),
                       fx_product(m[2], t3));
   endfunction

   // adjugate entry * 2^FRAC_BITS / det, bit-serial, saturated to the word
   function automatic longint fx_quotient(input longint num, input longint den,
                                          output logic clipped);
      logic [63:0] n, d, q, r, cap, posmax, negmax;
      logic        neg, over;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      cap = 64'd1 << WORD_WIDTH;
      posmax = (64'd1 << (WORD_WIDTH - 1)) - 1;
      negmax = 64'd1 << (WORD_WIDTH - 1);
      q = n / d;
      r = n % d;
      over = 1'b0;
      clipped = 1'b0;
      for (int k = 0; k < FRAC_BITS; k++) begin
         if (q > cap) begin
            over = 1'b1;
            break;
         end
         r = r << 1;
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q[0] = 1'b1;
         end
      end
      if (neg) begin
         if (over || q > negmax) begin
            clipped = 1'b1;
            return -longint'(negmax);
         end
         return -longint'(q);
      end
      if (over || q > posmax) begin
         clipped = 1'b1;
         return longint'(posmax);
      end
      return longint'(q);
   endfunction

   function automatic longint elem_at(input int i);
      return longint'($signed(elem_copy[i]));
   endfunction

   // full inverse of the stored matrix, queued as sixteen expected beats
   task automatic predict_inverse();
      longint       adj [16];
      longint       m [9];
      longint       det, v;
      int           n;
      logic         clipped;
      inv_elem_type e;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            n = 0;
            for (int i = 0; i < 4; i++) begin
               for (int j = 0; j < 4; j++) begin
                  if (i != r && j != c) begin
                     m[n] = elem_at(i * 4 + j);
                     n++;
                  end
               end
            end
            v = minor_det(m);
            adj[c * 4 + r] = ((r + c) % 2 == 1) ? -v : v;
         end
      end
      det = 0;
      for (int c = 0; c < 4; c++) det = clamp_sum(det, fx_product(elem_at(c), adj[c * 4]));
      for (int k = 0; k < 16; k++) begin
         clipped = 1'b0;
         v = 0;
         if (det != 0) v = fx_quotient(adj[k], det, clipped);
         e.value = v[WORD_WIDTH-1:0];
         e.index = 4'(k);
         e.singular = (det == 0);
         e.saturated = clipped;
         e.last = (k == 15);
         inverse_q.push_back(e);
      end
   endtask

   // typed-in results for the identity and singular directed runs
   task automatic push_typed(input chk_mode_type mode);
      inv_elem_type e;
      for (int k = 0; k < 16; k++) begin
         e.value = (mode == CHK_IDENTITY && k % 5 == 0) ? 32'h0001_0000 : '0;
         e.index = 4'(k);
         e.singular = (mode == CHK_SINGULAR);
         e.saturated = 1'b0;
         e.last = (k == 15);
         inverse_q.push_back(e);
      end
   endtask

   // ---------------------------------------------------------------- monitors
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         // the prediction reads the store with this element already written
         elem_copy[req_element_index] = req_element_value;
         if (req_element_index == LAST_IDX) begin
            if (req_mode == CHK_MODEL) predict_inverse();
            else push_typed(req_mode);
         end
      end
   end

   always @(posedge clock) begin
      inv_elem_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_beats++;
         if (inverse_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected inverse beat: value %h index %0d",
                        rsp_result_value, rsp_result_index);
         end else begin
            want = inverse_q.pop_front();
            if (want != {rsp_result_value, rsp_result_index, rsp_singular,
                         rsp_saturated, rsp_last_result}) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"inverse mismatch: want v=%h i=%0d sg=%b st=%b l=%b,",
                            " got v=%h i=%0d sg=%b st=%b l=%b"},
                           want.value, want.index, want.singular, want.saturated, want.last,
                           rsp_result_value, rsp_result_index, rsp_singular,
                           rsp_saturated, rsp_last_result);
            end
         end
      end
   end

   // watchdog: no beat moving on either side for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // mostly back-to-back, sometimes a short gap, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // ---------------------------------------------------------------- receiver
   initial begin
      int  n;
      bit  long_done;
      long_done = 0;
      @(posedge clock);
      wait (!reset);
      forever begin
         // one long hold so the block fills and backs up the element beats
         if (!long_done && rsp_beats >= 20) begin
            long_done = 1;
            n = 4000;
         end else n = gap_len();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         n = $urandom_range(1, 40);
         repeat (n) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------- sender
   task automatic send_beat(input logic [31:0] v, input logic [3:0] i,
                            input chk_mode_type mode);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_element_value <= v;
      req_element_index <= i;
      req_mode <= mode;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   function automatic logic [31:0] rand_elem(input bit wide);
      // small values within +-4.0 keep the determinant well scaled
      if (wide) return $urandom;
      return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
   endfunction

   stim_row_type directed [] = '{
      // identity: inverse is the identity
      '{32'h0001_0000, 4'd0,  CHK_MODEL}, '{32'h0,        4'd1,  CHK_MODEL},
      '{32'h0,        4'd2,  CHK_MODEL}, '{32'h0,        4'd3,  CHK_MODEL},
      '{32'h0,        4'd4,  CHK_MODEL}, '{32'h0001_0000, 4'd5,  CHK_MODEL},
      '{32'h0,        4'd6,  CHK_MODEL}, '{32'h0,        4'd7,  CHK_MODEL},
      '{32'h0,        4'd8,  CHK_MODEL}, '{32'h0,        4'd9,  CHK_MODEL},
      '{32'h0001_0000, 4'd10, CHK_MODEL}, '{32'h0,        4'd11, CHK_MODEL},
      '{32'h0,        4'd12, CHK_MODEL}, '{32'h0,        4'd13, CHK_MODEL},
      '{32'h0,        4'd14, CHK_MODEL}, '{32'h0001_0000, 4'd15, CHK_IDENTITY},
      // same element 15 again starts a fresh run
      '{32'h0001_0000, 4'd15, CHK_IDENTITY},
      // zero pivot on the diagonal makes it singular
      '{32'h0,        4'd0,  CHK_MODEL}, '{32'h0001_0000, 4'd15, CHK_SINGULAR},
      // extremes of the element range, intermediate clamping
      '{32'h7FFF_FFFF, 4'd0,  CHK_MODEL}, '{32'h8000_0000, 4'd5,  CHK_MODEL},
      '{32'h7FFF_FFFF, 4'd10, CHK_MODEL}, '{32'h8000_0000, 4'd15, CHK_MODEL},
      // tiny diagonal: inverse clips to the word range
      '{32'h0000_0001, 4'd0,  CHK_MODEL}, '{32'h0000_0001, 4'd15, CHK_MODEL}
   };

   initial begin
      logic [3:0]  order [15];
      logic [3:0]  t;
      logic [31:0] m [16];
      int          kind, j, cnt;
      bit          paused;
      paused = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[k]) send_beat(directed[k].value, directed[k].index, directed[k].mode);

      while (items_sent < ITEM_GOAL) begin
         // once, let every expected result drain before going on
         if (!paused && items_sent > ITEM_GOAL / 2) begin
            paused = 1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (inverse_q.size() != 0) @(posedge clock);
         end
         kind = $urandom_range(0, 99);
         if (kind < 15) begin
            // partial rewrite, then a new run on the mostly old matrix
            cnt = $urandom_range(1, 3);
            for (int k = 0; k < cnt; k++)
               send_beat(rand_elem(kind < 5), 4'($urandom_range(0, 14)), CHK_MODEL);
            send_beat(rand_elem(0), LAST_IDX, CHK_MODEL);
         end else begin
            for (int k = 0; k < 16; k++) m[k] = rand_elem(kind >= 85);
            // repeated rows give a zero or nearly zero determinant
            if (kind < 25) for (int k = 0; k < 4; k++) m[4 + k] = m[k];
            for (int k = 0; k < 15; k++) order[k] = 4'(k);
            for (int k = 14; k > 0; k--) begin
               j = $urandom_range(0, k);
               t = order[k];
               order[k] = order[j];
               order[j] = t;
            end
            for (int k = 0; k < 15; k++) send_beat(m[order[k]], order[k], CHK_MODEL);
            send_beat(m[15], LAST_IDX, CHK_MODEL);
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (inverse_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
src/mi4_pkg.sv
src/mi4_ctrl.sv
src/mi4_datapath.sv
src/matrix4_inverse_adjugate.sv
sim/matrix4_inverse_adjugate_tb.sv
